// ----- src/page_bitmap_allocator_defines.svh -----
// Assertion macros for the page bitmap allocator.
// No dependencies; included by files that carry assertions.
`ifndef PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define PBA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pba assertion failed");
`define PBA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pba assertion failed");
`else
`define PBA_ASSERT(lbl, clk, rstn, prop)
`define PBA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- src/pba_pkg.sv -----
// Shared constants, codes and types of the page bitmap allocator.
// No dependencies.
package pba_pkg;
    localparam int MAX_PAGES     = 65536;
    localparam int MAP_WORD_BITS = 64;
    localparam int MAP_WORDS     = MAX_PAGES / MAP_WORD_BITS;
    localparam int WORD_AW       = $clog2(MAP_WORDS);
    localparam int BIT_W         = $clog2(MAP_WORD_BITS);
    localparam int CHUNK         = 8;
    localparam int CHUNK_W       = $clog2(CHUNK);
    localparam int PAGE_W        = 16;
    localparam int CNT_W         = 17;
    localparam int CMD_W         = 2;
    localparam int STAT_W        = 2;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_START = 1'b1;

    localparam logic [CNT_W-1:0]  TOTAL_RST = 17'd65536;
    localparam logic [PAGE_W-1:0] START_RST = 16'd512;

    typedef struct packed {
        logic [CNT_W-1:0]  total_pages;
        logic [PAGE_W-1:0] search_start;
    } t_cfg;
endpackage

// ----- src/pba_if.sv -----
// Request and response channel interfaces of the page bitmap allocator.
// Depends on pba_pkg.
interface pba_req_if import pba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PAGE_W-1:0] first_page;
    logic [CNT_W-1:0]  req_pages;
    modport source (output valid, command, first_page, req_pages, input ready);
    modport sink (input valid, command, first_page, req_pages, output ready);
endinterface

interface pba_rsp_if import pba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] granted_page;
    logic [CNT_W-1:0]  granted_count;
    logic [STAT_W-1:0] status;
    modport source (output valid, granted_page, granted_count, status, input ready);
    modport sink (input valid, granted_page, granted_count, status, output ready);
endinterface

// ----- src/pba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/pba_cfg.sv -----
// APB configuration registers: page count and search start.
// Depends on pba_pkg.
module pba_cfg import pba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);
    logic [CNT_W-1:0]  r_total;
    logic [PAGE_W-1:0] r_start;
    logic              w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RST;
            r_start <= START_RST;
        end else if (w_wr) begin
            case (paddr[2])
                REG_TOTAL: r_total <= pwdata[CNT_W-1:0];
                REG_START: r_start <= pwdata[PAGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TOTAL: prdata = APB_DW'(r_total);
            REG_START: prdata = APB_DW'(r_start);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = '{total_pages: r_total, search_start: r_start};
endmodule

// ----- src/page_bitmap_allocator.sv -----
// Allocate reads each bitmap word from the search start and scans it in 8-page chunks,
//   then marks the found run with a read and a write per word; free and reserve read
//   and write each word touched. Commands are handled one at a time; the next is taken
//   once the result is registered. The bitmap RAM has one write port and one read port.
// Reset: a clearing pass writes all 1024 bitmap words free, and no command is accepted
//   meanwhile; registers return to 65536 pages and search start 512.
`include "page_bitmap_allocator_defines.svh"
module page_bitmap_allocator import pba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pba_req_if.sink           i_req,
    pba_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_WRD   = 4'd4;
    localparam logic [3:0] S_WWR   = 4'd5;
    localparam logic [3:0] S_DONE  = 4'd6;
    localparam logic [MAP_WORD_BITS-1:0] ONES = '1;

    t_cfg w_cfg;

    logic [3:0]               r_state, n_state;
    logic [WORD_AW-1:0]       r_clr;
    logic [CNT_W-1:0]         r_count, r_limit, r_p, r_run, r_start, r_wcur, r_wend;
    logic                     r_set;
    logic [PAGE_W-1:0]        r_gpage;
    logic [CNT_W-1:0]         r_gcount;
    logic [STAT_W-1:0]        r_status;
    logic                     r_ov;
    logic [PAGE_W-1:0]        r_opage;
    logic [CNT_W-1:0]         r_ocount;
    logic [STAT_W-1:0]        r_ostat;

    logic                     w_we, w_re;
    logic [WORD_AW-1:0]       w_waddr, w_raddr;
    logic [MAP_WORD_BITS-1:0] w_wdata, w_rdata, w_mask;
    logic [CNT_W-1:0]         w_limit, w_run, w_start, w_next_p, w_last, w_endc;
    logic [CNT_W:0]           w_end;
    logic                     w_found, w_is_last, w_acc, w_load;
    logic [BIT_W-1:0]         w_hi;

    pba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pba_ram #(.WIDTH(MAP_WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_limit = (w_cfg.total_pages > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                             : w_cfg.total_pages;
    assign w_end   = (CNT_W+1)'(i_req.first_page) + (CNT_W+1)'(i_req.req_pages);
    assign w_endc  = (w_end > (CNT_W+1)'(w_limit)) ? w_limit : w_end[CNT_W-1:0];
    assign w_acc   = i_req.valid && i_req.ready;
    assign w_load  = (r_state == S_DONE) && (!r_ov || o_rsp.ready);
    assign i_req.ready = (r_state == S_IDLE);

    // scan one 8-page chunk of the current word
    always_comb begin
        logic [CNT_W-1:0] q;
        w_run   = r_run;
        w_start = r_start;
        w_found = 1'b0;
        for (int j = 0; j < CHUNK; j++) begin
            q = {r_p[CNT_W-1:CHUNK_W], CHUNK_W'(j)};
            if (!w_found && q >= r_p && q < r_limit) begin
                if (w_rdata[{r_p[BIT_W-1:CHUNK_W], CHUNK_W'(j)}]) begin
                    w_run   = '0;
                    w_start = q + 1'b1;
                end else begin
                    w_run = w_run + 1'b1;
                    if (w_run >= r_count) begin
                        w_found = 1'b1;
                    end
                end
            end
        end
        w_next_p = {r_p[CNT_W-1:CHUNK_W] + 1'b1, CHUNK_W'(0)};
    end

    assign w_last    = r_wend - 1'b1;
    assign w_is_last = (w_last[CNT_W-1:BIT_W] == r_wcur[CNT_W-1:BIT_W]);
    assign w_hi      = w_is_last ? w_last[BIT_W-1:0] : BIT_W'(MAP_WORD_BITS - 1);
    assign w_mask    = (ONES << r_wcur[BIT_W-1:0])
                     & (ONES >> (BIT_W'(MAP_WORD_BITS - 1) - w_hi));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wcur[BIT_W+WORD_AW-1:BIT_W];
        w_wdata = r_set ? (w_rdata | w_mask) : (w_rdata & ~w_mask);
        w_re    = 1'b0;
        w_raddr = r_wcur[BIT_W+WORD_AW-1:BIT_W];
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            S_SRD: begin
                w_re    = 1'b1;
                w_raddr = r_p[BIT_W+WORD_AW-1:BIT_W];
            end
            S_WRD: w_re = 1'b1;
            S_WWR: w_we = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == WORD_AW'(MAP_WORDS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_DONE;
                    if (i_req.command == CMD_ALLOC) begin
                        if (i_req.req_pages != '0
                                && CNT_W'(w_cfg.search_start) < w_limit) begin
                            n_state = S_SRD;
                        end
                    end else if (i_req.command == CMD_FREE
                            || i_req.command == CMD_RESERVE) begin
                        if (CNT_W'(i_req.first_page) < w_limit
                                && w_endc != CNT_W'(i_req.first_page)) begin
                            n_state = S_WRD;
                        end
                    end
                end
            end
            S_SRD: n_state = S_SCAN;
            S_SCAN: begin
                if (w_found) begin
                    n_state = S_WRD;
                end else if (w_next_p >= r_limit) begin
                    n_state = S_DONE;
                end else if (w_next_p[BIT_W-1:0] == '0) begin
                    n_state = S_SRD;
                end
            end
            S_WRD: n_state = S_WWR;
            S_WWR: n_state = w_is_last ? S_DONE : S_WRD;
            S_DONE: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_opage  <= r_gpage;
            r_ocount <= r_gcount;
            r_ostat  <= r_status;
        end
        case (r_state)
            S_IDLE: begin
                r_count  <= i_req.req_pages;
                r_limit  <= w_limit;
                r_p      <= CNT_W'(w_cfg.search_start);
                r_run    <= '0;
                r_start  <= CNT_W'(w_cfg.search_start);
                r_wcur   <= CNT_W'(i_req.first_page);
                r_wend   <= w_endc;
                r_set    <= (i_req.command == CMD_RESERVE);
                r_gpage  <= '0;
                r_gcount <= '0;
                r_status <= ST_BAD;
                if (i_req.command == CMD_ALLOC) begin
                    if (i_req.req_pages != '0) begin
                        r_status <= ST_NOFIT;
                    end
                end else if (i_req.command == CMD_FREE
                        || i_req.command == CMD_RESERVE) begin
                    if (CNT_W'(i_req.first_page) < w_limit) begin
                        r_status <= ST_OK;
                        r_gcount <= w_endc - CNT_W'(i_req.first_page);
                    end
                end
            end
            S_SCAN: begin
                r_p     <= w_next_p;
                r_run   <= w_run;
                r_start <= w_start;
                if (w_found) begin
                    r_gpage  <= w_start[PAGE_W-1:0];
                    r_gcount <= r_count;
                    r_status <= ST_OK;
                    r_wcur   <= w_start;
                    r_wend   <= w_start + r_count;
                    r_set    <= 1'b1;
                end
            end
            S_WWR: r_wcur <= {r_wcur[CNT_W-1:BIT_W] + 1'b1, BIT_W'(0)};
            default: ;
        endcase
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.granted_page  = r_opage;
    assign o_rsp.granted_count = r_ocount;
    assign o_rsp.status        = r_ostat;

    `PBA_ASSERT(a_no_accept_in_clear, i_clk, i_rst_n, (r_state == S_CLEAR) |-> !i_req.ready)
    `PBA_ASSERT(a_we_only_clear_or_wr, i_clk, i_rst_n, w_we |-> (r_state == S_CLEAR || r_state == S_WWR))
    `PBA_ASSERT(a_fail_zero_count, i_clk, i_rst_n, (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.granted_count == '0 && o_rsp.granted_page == '0))
    `PBA_ASSERT(a_scan_after_read, i_clk, i_rst_n, (r_state == S_SCAN && $past(r_state) != S_SCAN) |-> $past(r_state) == S_SRD)
endmodule

// ----- tb/tb.sv -----
// Testbench for page_bitmap_allocator: a directed table, then random phases,
// each result checked against the table's expected value or an in-bench page map predictor.
// Depends on pba_pkg, pba_if and the page_bitmap_allocator RTL.
`timescale 1ns / 1ps
module tb;
    import pba_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LONG_HOLD      = 400;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 150;

    typedef enum logic {K_ITEM, K_CFG} t_kind;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  count;
        logic [STAT_W-1:0] status;
    } t_grant;

    typedef struct {
        t_kind             kind;
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] first;
        logic [CNT_W-1:0]  count;
        logic              has_exp;
        t_grant            exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    pba_req_if req_if();
    pba_rsp_if rsp_if();

    page_bitmap_allocator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [MAX_PAGES-1:0] used_map;
    logic [CNT_W-1:0]     cfg_total;
    logic [PAGE_W-1:0]    cfg_start;

    t_grant grant_queue[$];
    logic   row_has_exp;
    t_grant row_exp;
    bit     long_hold_req;
    bit     quiet_mode;
    int     n_items, n_checked, n_cfg, n_err, idle_cycles;
    t_row   rows[$];

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic t_grant mk(int page, int count, logic [STAT_W-1:0] st);
        t_grant g;
        g.page = PAGE_W'(page);
        g.count = CNT_W'(count);
        g.status = st;
        return g;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet_mode || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic t_grant predict_grant(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] first,
                                             logic [CNT_W-1:0] count);
        t_grant g;
        int unsigned limit, p, run, start, stop;
        g = mk(0, 0, ST_BAD);
        limit = (cfg_total < MAX_PAGES) ? cfg_total : MAX_PAGES;
        if (cmd == CMD_ALLOC) begin
            if (count != 0) begin
                run = 0;
                start = cfg_start;
                g.status = ST_NOFIT;
                for (p = cfg_start; p < limit; p++) begin
                    if (used_map[p]) begin
                        run = 0;
                        start = p + 1;
                    end else begin
                        run++;
                        if (run >= count)
                            break;
                    end
                end
                if (run >= count) begin
                    for (p = start; p < start + count; p++)
                        used_map[p] = 1'b1;
                    g = mk(start, count, ST_OK);
                end
            end
        end else if (cmd == CMD_FREE || cmd == CMD_RESERVE) begin
            if (first < limit) begin
                stop = first + count;
                if (stop > limit)
                    stop = limit;
                for (p = first; p < stop; p++)
                    used_map[p] = (cmd == CMD_RESERVE);
                g = mk(0, stop - first, ST_OK);
            end
        end
        return g;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on response %0d: %s got %0d expected %0d", n_checked, field, got,
                 want);
        n_err++;
    endtask

    always @(posedge i_clk) begin
        t_grant want;
        if (req_if.valid && req_if.ready) begin
            want = predict_grant(req_if.command, req_if.first_page, req_if.req_pages);
            grant_queue.push_back(row_has_exp ? row_exp : want);
            n_items++;
        end
        if (rsp_if.valid && rsp_if.ready) begin
            if (grant_queue.size() == 0) begin
                $display("unexpected response transaction");
                n_err++;
            end else begin
                want = grant_queue.pop_front();
                if (rsp_if.granted_page !== want.page)
                    report_mismatch("granted_page", rsp_if.granted_page, want.page);
                if (rsp_if.granted_count !== want.count)
                    report_mismatch("granted_count", rsp_if.granted_count, want.count);
                if (rsp_if.status !== want.status)
                    report_mismatch("status", rsp_if.status, want.status);
            end
            n_checked++;
        end
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int g;
        rsp_if.ready = 1'b0;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                @(negedge i_clk) rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            g = pick_gap();
            if (g > 0) begin
                @(negedge i_clk) rsp_if.ready <= 1'b0;
                repeat (g - 1) @(negedge i_clk);
            end
            @(negedge i_clk) rsp_if.ready <= 1'b1;
        end
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] first,
                             logic [CNT_W-1:0] count, logic has_exp, t_grant exp);
        int g;
        g = pick_gap();
        @(negedge i_clk);
        if (g > 0) begin
            req_if.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.command <= cmd;
        req_if.first_page <= first;
        req_if.req_pages <= count;
        row_has_exp = has_exp;
        row_exp = exp;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
    endtask

    task automatic wait_idle();
        @(negedge i_clk) req_if.valid <= 1'b0;
        while (grant_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [APB_DW-1:0] value);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk) penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_TOTAL)
            cfg_total = value[CNT_W-1:0];
        else
            cfg_start = value[PAGE_W-1:0];
        n_cfg++;
    endtask

    task automatic add_item(logic [CMD_W-1:0] cmd, int first, int count, logic has_exp,
                            t_grant exp);
        t_row r;
        r.kind = K_ITEM;
        r.cmd = cmd;
        r.first = PAGE_W'(first);
        r.count = CNT_W'(count);
        r.has_exp = has_exp;
        r.exp = exp;
        rows.push_back(r);
    endtask

    task automatic add_cfg(logic idx, int value);
        t_row r;
        r.kind = K_CFG;
        r.cmd = {1'b0, idx};
        r.first = '0;
        r.count = CNT_W'(value);
        r.has_exp = 1'b0;
        r.exp = mk(0, 0, ST_OK);
        rows.push_back(r);
    endtask

    initial begin
        t_grant none;
        int limit, r, cmd, first, count, ph, k;
        bit big;
        none = mk(0, 0, ST_OK);
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.command = CMD_ALLOC;
        req_if.first_page = '0;
        req_if.req_pages = '0;
        row_has_exp = 1'b0;
        row_exp = none;
        used_map = '0;
        cfg_total = TOTAL_RST;
        cfg_start = START_RST;
        long_hold_req = 1'b0;
        quiet_mode = 1'b0;
        n_items = 0;
        n_checked = 0;
        n_cfg = 0;
        n_err = 0;
        idle_cycles = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        add_item(CMD_ALLOC, 0, 0, 1'b1, mk(0, 0, ST_BAD));
        add_item(2'd3, 16'hFFFF, 17'h1FFFF, 1'b1, mk(0, 0, ST_BAD));
        add_item(CMD_ALLOC, 0, 1, 1'b1, mk(512, 1, ST_OK));
        add_item(CMD_ALLOC, 0, 5, 1'b1, mk(513, 5, ST_OK));
        add_item(CMD_FREE, 65535, 65536, 1'b1, mk(0, 1, ST_OK));
        add_item(CMD_RESERVE, 0, 0, 1'b1, mk(0, 0, ST_OK));
        add_item(CMD_RESERVE, 100, 50, 1'b1, mk(0, 50, ST_OK));
        add_item(CMD_ALLOC, 0, 65536, 1'b1, mk(0, 0, ST_NOFIT));
        add_item(CMD_FREE, 512, 6, 1'b1, mk(0, 6, ST_OK));
        add_item(CMD_ALLOC, 0, 3, 1'b0, none);
        add_cfg(REG_TOTAL, 0);
        add_item(CMD_FREE, 0, 1, 1'b1, mk(0, 0, ST_BAD));
        add_item(CMD_ALLOC, 0, 1, 1'b1, mk(0, 0, ST_NOFIT));
        add_cfg(REG_TOTAL, 131071);
        add_item(CMD_RESERVE, 65535, 1, 1'b1, mk(0, 1, ST_OK));
        add_cfg(REG_START, 65535);
        add_item(CMD_ALLOC, 0, 1, 1'b1, mk(0, 0, ST_NOFIT));
        add_item(CMD_FREE, 65535, 1, 1'b1, mk(0, 1, ST_OK));
        add_item(CMD_ALLOC, 0, 1, 1'b1, mk(65535, 1, ST_OK));
        add_cfg(REG_START, 0);
        add_item(CMD_ALLOC, 0, 100, 1'b0, none);
        add_item(CMD_ALLOC, 0, 1, 1'b0, none);
        add_cfg(REG_TOTAL, 1000);
        add_item(CMD_RESERVE, 990, 20, 1'b1, mk(0, 10, ST_OK));

        foreach (rows[i]) begin
            if (rows[i].kind == K_CFG)
                write_reg(rows[i].cmd[0], APB_DW'(rows[i].count));
            else
                send_item(rows[i].cmd, rows[i].first, rows[i].count, rows[i].has_exp,
                          rows[i].exp);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            big = (ph == 2);
            limit = big ? 65536 : $urandom_range(4096, 64);
            write_reg(REG_TOTAL, big ? 131071 : limit);
            if (ph == 4)
                write_reg(REG_START, $urandom_range(65535, limit));
            else
                write_reg(REG_START, $urandom_range(limit / 2));
            quiet_mode = (ph == 3);
            if (ph == 1)
                long_hold_req = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(99);
                cmd = (r < 45) ? CMD_ALLOC : (r < 75) ? CMD_FREE : (r < 95) ? CMD_RESERVE : 3;
                first = ($urandom_range(9) == 0) ? $urandom_range(65535)
                                                 : $urandom_range(limit - 1);
                r = $urandom_range(99);
                if (r < 5)
                    count = 0;
                else if (r < 15 && !(big && cmd == CMD_ALLOC))
                    count = $urandom_range(131071);
                else
                    count = $urandom_range(64, 1);
                send_item(CMD_W'(cmd), PAGE_W'(first), CNT_W'(count), 1'b0, none);
            end
        end

        wait_idle();
        $display("covered %0d requests, %0d responses checked, %0d register writes",
                 n_items, n_checked, n_cfg);
        $display("directed edge cases plus %0d random phases of varied page limits", PHASES);
        if (n_err == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+src
src/pba_pkg.sv
src/pba_if.sv
src/pba_ram.sv
src/pba_cfg.sv
src/page_bitmap_allocator.sv
tb/tb.sv
